/* sv/lrnp_pkg.sv */
package lrnp_pkg;

  localparam int CAPACITY    = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int GROW_STEP   = 1024;
  localparam int MIN_COUNT   = 2;
  localparam int RESET_COUNT = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_NEW     = 3'd0;
  localparam logic [OP_W-1:0] OP_LINK    = 3'd1;
  localparam logic [OP_W-1:0] OP_UNLINK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DISMISS = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_CLR_STEP,
    DP_SCAN_STEP,
    DP_GROW_START,
    DP_ALLOC_FOUND,
    DP_ALLOC_GROW,
    DP_LINK_RD,
    DP_LINK_W1,
    DP_LINK_W2,
    DP_UNL_RD,
    DP_UNL_W1,
    DP_UNL_W2,
    DP_DISMISS,
    DP_REPORT_RD,
    DP_OUT_LOAD,
    DP_OUT_FULL,
    DP_OUT_ZERO
  } dp_step_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_ALLOC_GROW,
    S_LINK_RD,
    S_LINK_W1,
    S_LINK_W2,
    S_UNL_RD,
    S_UNL_W1,
    S_UNL_W2,
    S_DISMISS,
    S_REPORT,
    S_OUT,
    S_FULL,
    S_BAD
  } ctl_state_t;

  typedef struct packed {
    dp_step_t step;
    logic     in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic            found;
    logic            exhausted;
    logic            at_cap;
    logic            clr_done;
    logic            out_busy;
    logic [OP_W-1:0] op_in;
  } dp_status_t;

endpackage

/* sv/lrnp_if.sv */
interface lrnp_req_if;
  logic                          valid;
  logic                          ready;
  logic [lrnp_pkg::OP_W-1:0]     operation;
  logic [lrnp_pkg::IDX_W-1:0]    node_index;
  logic [lrnp_pkg::IDX_W-1:0]    root_index;
  logic [lrnp_pkg::DATA_W-1:0]   payload;

  modport source (output valid, operation, node_index, root_index, payload, input ready);
  modport sink   (input valid, operation, node_index, root_index, payload, output ready);
endinterface

interface lrnp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lrnp_pkg::IDX_W-1:0]    result_index;
  logic [lrnp_pkg::DATA_W-1:0]   result_payload;
  logic [lrnp_pkg::IDX_W-1:0]    result_next;
  logic [lrnp_pkg::IDX_W-1:0]    result_prev;
  logic                          status;

  modport source (output valid, result_index, result_payload, result_next, result_prev,
                  status, input ready);
  modport sink   (input valid, result_index, result_payload, result_next, result_prev,
                  status, output ready);
endinterface

/* sv/lrnp_dp.sv */
module lrnp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lrnp_pkg::CNT_W-1:0]    cfg_wdata,
  input  lrnp_pkg::dp_cmd_t             cmd,
  output lrnp_pkg::dp_status_t          st,
  input  logic                          req_valid,
  input  logic [lrnp_pkg::OP_W-1:0]     req_operation,
  input  logic [lrnp_pkg::IDX_W-1:0]    req_node_index,
  input  logic [lrnp_pkg::IDX_W-1:0]    req_root_index,
  input  logic [lrnp_pkg::DATA_W-1:0]   req_payload,
  lrnp_rsp_if.source                    rsp
);

  localparam int IW = lrnp_pkg::IDX_W;
  localparam int CW = lrnp_pkg::CNT_W;
  localparam int DW = lrnp_pkg::DATA_W;

  // node stores
  logic [DW-1:0] pay_mem  [lrnp_pkg::CAPACITY];
  logic [IW-1:0] next_mem [lrnp_pkg::CAPACITY];
  logic [IW-1:0] prev_mem [lrnp_pkg::CAPACITY];

  logic [DW-1:0] pay_rd;
  logic [IW-1:0] next_rd;
  logic [IW-1:0] prev_rd;

  logic [CW-1:0] active_count;
  logic [CW-1:0] scan_position;
  logic [CW-1:0] grown_count;
  logic [IW-1:0] op_node;
  logic [IW-1:0] op_root;
  logic [DW-1:0] op_data;
  logic [IW-1:0] rep_idx;
  logic [CW-1:0] scan_ptr;
  logic [CW-1:0] probes_left;
  logic          probe_v;
  logic [IW-1:0] probe_addr;
  logic [CW-1:0] clr_ptr;
  logic [CW-1:0] clr_end;

  lrnp_pkg::dp_step_t step;

  logic          pay_we, next_we, prev_we;
  logic [IW-1:0] pay_wa, next_wa, prev_wa;
  logic [DW-1:0] pay_wd;
  logic [IW-1:0] next_wd, prev_wd;
  logic          pay_re, next_re, prev_re;
  logic [IW-1:0] pay_ra, next_ra, prev_ra;

  logic [CW-1:0] scan_start;
  logic [CW-1:0] scan_inc;
  logic [CW:0]   grow_raw;
  logic [CW:0]   grow_cap;
  logic [CW-1:0] cfg_clamped;

  assign step = cfg_we ? lrnp_pkg::DP_NOP : cmd.step;

  always_comb begin
    if (scan_position == '0 || scan_position >= active_count) begin
      scan_start = CW'(1);
    end else begin
      scan_start = scan_position;
    end
    scan_inc = scan_ptr + CW'(1);
    if (active_count >= CW'(lrnp_pkg::GROW_STEP)) begin
      grow_raw = {1'b0, active_count} + (CW+1)'(lrnp_pkg::GROW_STEP);
    end else begin
      grow_raw = {active_count, 1'b0};
    end
    if (grow_raw > (CW+1)'(lrnp_pkg::CAPACITY)) begin
      grow_cap = (CW+1)'(lrnp_pkg::CAPACITY);
    end else begin
      grow_cap = grow_raw;
    end
    if (cfg_wdata < CW'(lrnp_pkg::MIN_COUNT)) begin
      cfg_clamped = CW'(lrnp_pkg::MIN_COUNT);
    end else if (cfg_wdata > CW'(lrnp_pkg::CAPACITY)) begin
      cfg_clamped = CW'(lrnp_pkg::CAPACITY);
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  // memory port steering
  always_comb begin
    pay_we  = 1'b0;  pay_wa  = clr_ptr[IW-1:0];  pay_wd  = '0;
    next_we = 1'b0;  next_wa = clr_ptr[IW-1:0];  next_wd = '0;
    prev_we = 1'b0;  prev_wa = clr_ptr[IW-1:0];  prev_wd = '0;
    pay_re  = 1'b0;  pay_ra  = rep_idx;
    next_re = 1'b0;  next_ra = rep_idx;
    prev_re = 1'b0;  prev_ra = rep_idx;
    case (step)
      lrnp_pkg::DP_CLR_STEP: begin
        pay_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      lrnp_pkg::DP_SCAN_STEP: begin
        pay_re = (probes_left != '0);
        pay_ra = scan_ptr[IW-1:0];
      end
      lrnp_pkg::DP_ALLOC_FOUND: begin
        pay_we  = 1'b1;  pay_wa  = probe_addr;  pay_wd  = op_data;
        next_we = 1'b1;  next_wa = probe_addr;  next_wd = probe_addr;
        prev_we = 1'b1;  prev_wa = probe_addr;  prev_wd = probe_addr;
      end
      lrnp_pkg::DP_ALLOC_GROW: begin
        pay_we  = 1'b1;  pay_wa  = active_count[IW-1:0];  pay_wd  = op_data;
        next_we = 1'b1;  next_wa = active_count[IW-1:0];  next_wd = active_count[IW-1:0];
        prev_we = 1'b1;  prev_wa = active_count[IW-1:0];  prev_wd = active_count[IW-1:0];
      end
      lrnp_pkg::DP_LINK_RD: begin
        next_re = 1'b1;
        next_ra = op_root;
      end
      lrnp_pkg::DP_LINK_W1: begin
        prev_we = 1'b1;  prev_wa = op_node;  prev_wd = op_root;
        next_we = 1'b1;  next_wa = op_node;  next_wd = next_rd;
      end
      lrnp_pkg::DP_LINK_W2: begin
        prev_we = 1'b1;  prev_wa = next_rd;  prev_wd = op_node;
        next_we = 1'b1;  next_wa = op_root;  next_wd = op_node;
      end
      lrnp_pkg::DP_UNL_RD: begin
        next_re = 1'b1;  next_ra = op_node;
        prev_re = 1'b1;  prev_ra = op_node;
      end
      lrnp_pkg::DP_UNL_W1: begin
        prev_we = 1'b1;  prev_wa = next_rd;  prev_wd = prev_rd;
        next_we = 1'b1;  next_wa = prev_rd;  next_wd = next_rd;
      end
      lrnp_pkg::DP_UNL_W2: begin
        next_we = 1'b1;  next_wa = op_node;  next_wd = op_node;
        prev_we = 1'b1;  prev_wa = op_node;  prev_wd = op_node;
      end
      lrnp_pkg::DP_DISMISS: begin
        pay_we = 1'b1;
        pay_wa = op_node;
      end
      lrnp_pkg::DP_REPORT_RD: begin
        pay_re  = 1'b1;
        next_re = 1'b1;
        prev_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= pay_wd;
    end
    if (pay_re) begin
      pay_rd <= pay_mem[pay_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (next_re) begin
      next_rd <= next_mem[next_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (prev_re) begin
      prev_rd <= prev_mem[prev_ra];
    end
  end

  // pool bookkeeping and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count  <= CW'(lrnp_pkg::RESET_COUNT);
      scan_position <= CW'(1);
      clr_ptr       <= '0;
      clr_end       <= CW'(lrnp_pkg::CAPACITY - 1);
      probe_v       <= 1'b0;
    end else if (cfg_we) begin
      active_count  <= cfg_clamped;
      scan_position <= CW'(1);
      clr_ptr       <= '0;
      clr_end       <= CW'(lrnp_pkg::CAPACITY - 1);
      probe_v       <= 1'b0;
    end else begin
      case (step)
        lrnp_pkg::DP_LATCH: begin
          scan_ptr    <= scan_start;
          probes_left <= active_count - CW'(1);
          probe_v     <= 1'b0;
        end
        lrnp_pkg::DP_SCAN_STEP: begin
          if (probes_left != '0) begin
            probe_addr  <= scan_ptr[IW-1:0];
            probe_v     <= 1'b1;
            probes_left <= probes_left - CW'(1);
            scan_ptr    <= (scan_inc >= active_count) ? CW'(1) : scan_inc;
          end else begin
            probe_v <= 1'b0;
          end
        end
        lrnp_pkg::DP_CLR_STEP: begin
          clr_ptr <= clr_ptr + CW'(1);
        end
        lrnp_pkg::DP_GROW_START: begin
          clr_ptr     <= active_count;
          clr_end     <= grow_cap[CW-1:0] - CW'(1);
          grown_count <= grow_cap[CW-1:0];
        end
        lrnp_pkg::DP_ALLOC_FOUND: begin
          scan_position <= {1'b0, probe_addr} + CW'(1);
        end
        lrnp_pkg::DP_ALLOC_GROW: begin
          scan_position <= active_count + CW'(1);
          active_count  <= grown_count;
        end
        default: begin
        end
      endcase
    end
  end

  // item fields and report index
  always_ff @(posedge clk) begin
    case (step)
      lrnp_pkg::DP_LATCH: begin
        op_node <= req_node_index;
        op_root <= req_root_index;
        op_data <= req_payload;
        rep_idx <= req_node_index;
      end
      lrnp_pkg::DP_ALLOC_FOUND: begin
        rep_idx <= probe_addr;
      end
      lrnp_pkg::DP_ALLOC_GROW: begin
        rep_idx <= active_count[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (step inside {lrnp_pkg::DP_OUT_LOAD, lrnp_pkg::DP_OUT_FULL,
                              lrnp_pkg::DP_OUT_ZERO}) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (step)
      lrnp_pkg::DP_OUT_LOAD: begin
        rsp.result_index   <= rep_idx;
        rsp.result_payload <= pay_rd;
        rsp.result_next    <= next_rd;
        rsp.result_prev    <= prev_rd;
        rsp.status         <= 1'b0;
      end
      lrnp_pkg::DP_OUT_FULL, lrnp_pkg::DP_OUT_ZERO: begin
        rsp.result_index   <= '0;
        rsp.result_payload <= '0;
        rsp.result_next    <= '0;
        rsp.result_prev    <= '0;
        rsp.status         <= (step == lrnp_pkg::DP_OUT_FULL);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st.found     = probe_v && (pay_rd == '0);
    st.exhausted = !probe_v && (probes_left == '0);
    st.at_cap    = (active_count == CW'(lrnp_pkg::CAPACITY));
    st.clr_done  = (clr_ptr == clr_end);
    st.out_busy  = rsp.valid && !rsp.ready;
    st.op_in     = req_valid ? req_operation : lrnp_pkg::OP_READ;
  end

endmodule

/* sv/lrnp_ctrl.sv */
module lrnp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  req_valid,
  input  lrnp_pkg::dp_status_t  st,
  output lrnp_pkg::dp_cmd_t     cmd
);

  lrnp_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrnp_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.step     = lrnp_pkg::DP_NOP;
    cmd.in_ready = 1'b0;
    if (cfg_we) begin
      state_next = lrnp_pkg::S_CLEAR;
    end else begin
      case (state)
        lrnp_pkg::S_CLEAR: begin
          cmd.step = lrnp_pkg::DP_CLR_STEP;
          if (st.clr_done) begin
            state_next = lrnp_pkg::S_IDLE;
          end
        end
        lrnp_pkg::S_IDLE: begin
          cmd.in_ready = 1'b1;
          if (req_valid) begin
            cmd.step = lrnp_pkg::DP_LATCH;
            case (st.op_in)
              lrnp_pkg::OP_NEW:     state_next = lrnp_pkg::S_SCAN;
              lrnp_pkg::OP_LINK:    state_next = lrnp_pkg::S_LINK_RD;
              lrnp_pkg::OP_UNLINK:  state_next = lrnp_pkg::S_UNL_RD;
              lrnp_pkg::OP_DISMISS: state_next = lrnp_pkg::S_DISMISS;
              lrnp_pkg::OP_READ:    state_next = lrnp_pkg::S_REPORT;
              default:              state_next = lrnp_pkg::S_BAD;
            endcase
          end
        end
        lrnp_pkg::S_SCAN: begin
          if (st.found) begin
            cmd.step   = lrnp_pkg::DP_ALLOC_FOUND;
            state_next = lrnp_pkg::S_REPORT;
          end else if (st.exhausted) begin
            if (st.at_cap) begin
              state_next = lrnp_pkg::S_FULL;
            end else begin
              cmd.step   = lrnp_pkg::DP_GROW_START;
              state_next = lrnp_pkg::S_GROW;
            end
          end else begin
            cmd.step = lrnp_pkg::DP_SCAN_STEP;
          end
        end
        lrnp_pkg::S_GROW: begin
          cmd.step = lrnp_pkg::DP_CLR_STEP;
          if (st.clr_done) begin
            state_next = lrnp_pkg::S_ALLOC_GROW;
          end
        end
        lrnp_pkg::S_ALLOC_GROW: begin
          cmd.step   = lrnp_pkg::DP_ALLOC_GROW;
          state_next = lrnp_pkg::S_REPORT;
        end
        lrnp_pkg::S_LINK_RD: begin
          cmd.step   = lrnp_pkg::DP_LINK_RD;
          state_next = lrnp_pkg::S_LINK_W1;
        end
        lrnp_pkg::S_LINK_W1: begin
          cmd.step   = lrnp_pkg::DP_LINK_W1;
          state_next = lrnp_pkg::S_LINK_W2;
        end
        lrnp_pkg::S_LINK_W2: begin
          cmd.step   = lrnp_pkg::DP_LINK_W2;
          state_next = lrnp_pkg::S_REPORT;
        end
        lrnp_pkg::S_UNL_RD: begin
          cmd.step   = lrnp_pkg::DP_UNL_RD;
          state_next = lrnp_pkg::S_UNL_W1;
        end
        lrnp_pkg::S_UNL_W1: begin
          cmd.step   = lrnp_pkg::DP_UNL_W1;
          state_next = lrnp_pkg::S_UNL_W2;
        end
        lrnp_pkg::S_UNL_W2: begin
          cmd.step   = lrnp_pkg::DP_UNL_W2;
          state_next = lrnp_pkg::S_REPORT;
        end
        lrnp_pkg::S_DISMISS: begin
          cmd.step   = lrnp_pkg::DP_DISMISS;
          state_next = lrnp_pkg::S_REPORT;
        end
        lrnp_pkg::S_REPORT: begin
          cmd.step   = lrnp_pkg::DP_REPORT_RD;
          state_next = lrnp_pkg::S_OUT;
        end
        lrnp_pkg::S_OUT: begin
          if (!st.out_busy) begin
            cmd.step   = lrnp_pkg::DP_OUT_LOAD;
            state_next = lrnp_pkg::S_IDLE;
          end
        end
        lrnp_pkg::S_FULL: begin
          if (!st.out_busy) begin
            cmd.step   = lrnp_pkg::DP_OUT_FULL;
            state_next = lrnp_pkg::S_IDLE;
          end
        end
        lrnp_pkg::S_BAD: begin
          if (!st.out_busy) begin
            cmd.step   = lrnp_pkg::DP_OUT_ZERO;
            state_next = lrnp_pkg::S_IDLE;
          end
        end
        default: begin
          state_next = lrnp_pkg::S_CLEAR;
        end
      endcase
    end
  end

endmodule

/* sv/linked_ring_node_pool.sv */
// channel   dir  handshake        beat contents
// req       in   valid / ready    operation, node_index, root_index, payload
// rsp       out  valid / ready    result_index, result_payload, result_next,
//                                 result_prev, status
// cfg       in   cfg_we           cfg_wdata = initial_count
//
// new probes the payload store for a node whose payload is zero; if
// none is found and the pool is not at capacity, a growth first zeroes
// the added nodes, and the first of them is allocated
// reset and every initial_count write run a sweep that zeroes all 1024
// entries of the stores; no beat is taken on req during it
// one item at a time; the next beat is taken while a result waits on rsp
module linked_ring_node_pool (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lrnp_pkg::CNT_W-1:0]    cfg_wdata,
  lrnp_req_if.sink                      req,
  lrnp_rsp_if.source                    rsp
);

  // command and status between sequencer and datapath
  lrnp_pkg::dp_cmd_t    cmd;
  lrnp_pkg::dp_status_t st;

  // req beat taken only in idle, with no config write in the same cycle
  assign req.ready = cmd.in_ready;

  lrnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .req_valid (req.valid),
    .st        (st),
    .cmd       (cmd)
  );

  // node stores, scan pointer, grow sweep and result register
  lrnp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .st             (st),
    .req_valid      (req.valid),
    .req_operation  (req.operation),
    .req_node_index (req.node_index),
    .req_root_index (req.root_index),
    .req_payload    (req.payload),
    .rsp            (rsp)
  );

endmodule
